### rtl/core/amde_pkg.sv
// Shared types, codes and arithmetic helpers for the atom map density energy block.
// Depends on nothing; used by rtl/core/atom_map_density_energy.sv.
package amde_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_INV_SAMPLING  = 3'd0,
    CFG_ORIGIN_X      = 3'd1,
    CFG_ORIGIN_Y      = 3'd2,
    CFG_ORIGIN_Z      = 3'd3,
    CFG_FORCE_SCALE   = 3'd4,
    CFG_ENERGY_GAIN   = 3'd5,
    CFG_ENERGY_OFFSET = 3'd6
  } cfg_idx_t;

  // Request kinds
  localparam logic REQ_VOXEL = 1'b0;
  localparam logic REQ_ATOM  = 1'b1;

  // Stencil taps, in read order
  typedef enum logic [2:0] {
    TAP_C  = 3'd0,
    TAP_XP = 3'd1,
    TAP_XN = 3'd2,
    TAP_YP = 3'd3,
    TAP_YN = 3'd4,
    TAP_ZP = 3'd5,
    TAP_ZN = 3'd6
  } tap_t;

  localparam int NTAPS = 7;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_MUL  = 12'b0000_0000_0010,
    ST_POS  = 12'b0000_0000_0100,
    ST_IDX  = 12'b0000_0000_1000,
    ST_RD   = 12'b0000_0001_0000,
    ST_DRN  = 12'b0000_0010_0000,
    ST_FMUL = 12'b0000_0100_0000,
    ST_FSAT = 12'b0000_1000_0000,
    ST_DIV  = 12'b0001_0000_0000,
    ST_EMUL = 12'b0010_0000_0000,
    ST_EFIN = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

  localparam int DIV_STEPS = 56;

  // Voxel coordinate strictly inside (0 < v < size-1); t is Q.32 position
  function automatic logic axis_ok(input logic signed [57:0] t, input logic [10:0] size);
    logic signed [25:0] hi;
    logic signed [25:0] lim;
    hi  = t[57:32];
    lim = $signed({15'b0, size}) - 26'sd1;
    return (hi >= 26'sd1) && (hi < lim);
  endfunction

  // Round |d|*scale to Q16.16, saturate to 40 bits and apply the sign
  function automatic logic [39:0] sat_force(input logic neg, input logic [64:0] prod);
    logic [64:0] rnd;
    logic [49:0] r;
    rnd = (prod + 65'd32768) >> 16;
    r   = rnd[49:0];
    if (neg) begin
      if (r > 50'h80_0000_0000) r = 50'h80_0000_0000;
      return 40'(50'd0 - r);
    end else begin
      if (r > 50'h7F_FFFF_FFFF) r = 50'h7F_FFFF_FFFF;
      return r[39:0];
    end
  endfunction

endpackage

### rtl/core/atom_map_density_energy.sv
// Atom to density map fit energy: voxel map memory, stencil reader, force and energy datapath.
// Depends on amde_pkg (types, codes, rounding helpers).
//
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_stall   | req_type, voxel_addr, voxel_value, coord_*, last_atom
//  out     | out       | out_valid / out_stall | force_*, atom_inside, energy, energy_valid, no_atoms
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A voxel write is taken in idle. An inside atom's time is set by the seven
// reads of the single map port; an outside atom skips them. The last atom of a molecule
// adds the bit-serial 56-step division and the energy multiply.
// rst clears control state, the sum and the count and loads the configuration defaults; the map keeps no reset.
// A waiting result sits in the output register; the sequencer stalls only when it
// must hand a second result over while the first is still held.
module atom_map_density_energy #(
  parameter int MAP_X     = 64,
  parameter int MAP_Y     = 64,
  parameter int MAP_Z     = 64,
  parameter int MAX_ATOMS = 16777215
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [17:0]        voxel_addr,
  input  logic signed [31:0] voxel_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic               last_atom,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [39:0] force_x,
  output logic signed [39:0] force_y,
  output logic signed [39:0] force_z,
  output logic               atom_inside,
  output logic signed [47:0] energy,
  output logic               energy_valid,
  output logic               no_atoms,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int VOXELS = MAP_X * MAP_Y * MAP_Z;
  localparam int AW     = $clog2(VOXELS);
  localparam int XW     = $clog2(MAP_X);
  localparam int YW     = $clog2(MAP_Y);
  localparam int ZW     = $clog2(MAP_Z);
  localparam logic [AW-1:0] SX  = AW'(MAP_X);
  localparam logic [AW-1:0] SXY = AW'(MAP_X * MAP_Y);
  localparam logic [23:0]   CNT_MAX = 24'(MAX_ATOMS);

  // Configuration registers
  logic [23:0]        inv_sampling;
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [31:0]        force_scale;
  logic signed [31:0] energy_gain, energy_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_sampling  <= 24'd65536;
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      force_scale   <= 32'd32768;
      energy_gain   <= 32'sd65536;
      energy_offset <= 32'sd655360;
    end else if (cfg_valid && cfg_ready) begin
      unique case (amde_pkg::cfg_idx_t'(cfg_index))
        amde_pkg::CFG_INV_SAMPLING:  inv_sampling  <= cfg_data[23:0];
        amde_pkg::CFG_ORIGIN_X:      origin_x      <= cfg_data;
        amde_pkg::CFG_ORIGIN_Y:      origin_y      <= cfg_data;
        amde_pkg::CFG_ORIGIN_Z:      origin_z      <= cfg_data;
        amde_pkg::CFG_FORCE_SCALE:   force_scale   <= cfg_data;
        amde_pkg::CFG_ENERGY_GAIN:   energy_gain   <= cfg_data;
        amde_pkg::CFG_ENERGY_OFFSET: energy_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  amde_pkg::state_t state;
  logic in_acc;
  logic out_free;

  assign in_stall = (state != amde_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Density map: one write port in idle, one registered read port in the stencil walk
  logic signed [31:0] map_mem [VOXELS];
  logic signed [31:0] mem_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  assign wr_en = in_acc && (req_type == amde_pkg::REQ_VOXEL) && (32'(voxel_addr) < 32'(VOXELS));

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[AW'(voxel_addr)] <= voxel_value;
    if (rd_en) mem_q <= map_mem[rd_addr];
  end

  // Atom datapath registers
  logic signed [31:0] cx, cy, cz;
  logic               last_r;
  logic signed [56:0] pm_x, pm_y, pm_z;
  logic               in_map;
  logic [XW-1:0]      vx;
  logic [YW-1:0]      vy;
  logic [ZW-1:0]      vz;
  logic [AW-1:0]      idx;
  amde_pkg::tap_t     rd_cnt;
  amde_pkg::tap_t     p1_tag;
  logic               p1_vld;
  logic signed [31:0] dens [amde_pkg::NTAPS];
  logic [64:0]        fp_x, fp_y, fp_z;
  logic               fn_x, fn_y, fn_z;
  logic signed [55:0] density_sum;
  logic [23:0]        atom_count;
  logic [39:0]        res_fx, res_fy, res_fz;
  logic               res_last, res_na;
  logic signed [47:0] res_en;
  logic [23:0]        div_den;
  logic [55:0]        div_q;
  logic [23:0]        div_rem;
  logic               div_neg;
  logic [5:0]         div_cnt;
  logic [63:0]        e_prod;
  logic               e_neg;

  // Position, per axis: Q.32 with the half-voxel rounding term
  logic signed [57:0] t_x, t_y, t_z;
  assign t_x = 58'(pm_x) + (58'(origin_x) <<< 16) + 58'sd2147483648;
  assign t_y = 58'(pm_y) + (58'(origin_y) <<< 16) + 58'sd2147483648;
  assign t_z = 58'(pm_z) + (58'(origin_z) <<< 16) + 58'sd2147483648;

  // Stencil address per tap
  always_comb begin
    case (rd_cnt)
      amde_pkg::TAP_C:  rd_addr = idx;
      amde_pkg::TAP_XP: rd_addr = idx + AW'(1);
      amde_pkg::TAP_XN: rd_addr = idx - AW'(1);
      amde_pkg::TAP_YP: rd_addr = idx + SX;
      amde_pkg::TAP_YN: rd_addr = idx - SX;
      amde_pkg::TAP_ZP: rd_addr = idx + SXY;
      default:          rd_addr = idx - SXY;
    endcase
  end
  assign rd_en = (state == amde_pkg::ST_RD);

  // Central differences and magnitudes
  logic signed [32:0] d_x, d_y, d_z;
  logic [32:0]        m_x, m_y, m_z;
  assign d_x = 33'(dens[amde_pkg::TAP_XP]) - 33'(dens[amde_pkg::TAP_XN]);
  assign d_y = 33'(dens[amde_pkg::TAP_YP]) - 33'(dens[amde_pkg::TAP_YN]);
  assign d_z = 33'(dens[amde_pkg::TAP_ZP]) - 33'(dens[amde_pkg::TAP_ZN]);
  assign m_x = d_x[32] ? 33'(-d_x) : 33'(d_x);
  assign m_y = d_y[32] ? 33'(-d_y) : 33'(d_y);
  assign m_z = d_z[32] ? 33'(-d_z) : 33'(d_z);

  // Sum and count update for the atom in flight
  logic signed [56:0] sum_dif;
  logic signed [55:0] sum_new;
  logic [23:0]        cnt_new;
  always_comb begin
    sum_dif = in_map ? 57'(density_sum) - 57'(dens[amde_pkg::TAP_C]) : 57'(density_sum);
    if (sum_dif > 57'sh7F_FFFF_FFFF_FFFF)       sum_new = 56'sh7F_FFFF_FFFF_FFFF;
    else if (sum_dif < -57'sh80_0000_0000_0000) sum_new = 56'sh80_0000_0000_0000;
    else                                        sum_new = sum_dif[55:0];
    cnt_new = (atom_count < CNT_MAX) ? atom_count + 24'd1 : atom_count;
  end

  // One restoring division step
  logic [24:0] div_sh;
  logic        div_bit;
  assign div_sh  = {div_rem, div_q[55]};
  assign div_bit = (div_sh >= {1'b0, div_den});

  // Mean saturated to 32 bits, as a magnitude
  logic [31:0] mean_mag;
  always_comb begin
    if (div_neg) mean_mag = (div_q > 56'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
    else         mean_mag = (div_q > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
  end

  // Energy: rounded product plus offset, saturated to 48 bits
  logic [63:0]        e_rnd;
  logic signed [49:0] e_sum;
  logic signed [47:0] e_sat;
  always_comb begin
    e_rnd = (e_prod + 64'd32768) >> 16;
    e_sum = e_neg ? -$signed({2'b0, e_rnd[47:0]}) : $signed({2'b0, e_rnd[47:0]});
    e_sum = e_sum + 50'(energy_offset);
    if (e_sum > 50'sh7FFF_FFFF_FFFF)       e_sat = 48'sh7FFF_FFFF_FFFF;
    else if (e_sum < -50'sh8000_0000_0000) e_sat = 48'sh8000_0000_0000;
    else                                   e_sat = e_sum[47:0];
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= amde_pkg::ST_IDLE;
      density_sum <= '0;
      atom_count  <= '0;
      p1_vld      <= 1'b0;
      out_valid   <= 1'b0;
      rd_cnt      <= amde_pkg::TAP_C;
    end else begin
      // capture the registered read data into the slot of its tap
      p1_vld <= rd_en;
      p1_tag <= rd_cnt;
      if (p1_vld) dens[p1_tag] <= mem_q;

      // drop the output item once taken, unless a new one replaces it
      if (out_valid && !out_stall && state != amde_pkg::ST_DONE) out_valid <= 1'b0;

      unique case (state)
        amde_pkg::ST_IDLE: begin
          if (in_acc && req_type == amde_pkg::REQ_ATOM) begin
            cx     <= coord_x;
            cy     <= coord_y;
            cz     <= coord_z;
            last_r <= last_atom;
            state  <= amde_pkg::ST_MUL;
          end
        end
        amde_pkg::ST_MUL: begin
          pm_x  <= cx * $signed({1'b0, inv_sampling});
          pm_y  <= cy * $signed({1'b0, inv_sampling});
          pm_z  <= cz * $signed({1'b0, inv_sampling});
          state <= amde_pkg::ST_POS;
        end
        amde_pkg::ST_POS: begin
          in_map <= amde_pkg::axis_ok(t_x, 11'(MAP_X)) && amde_pkg::axis_ok(t_y, 11'(MAP_Y))
                    && amde_pkg::axis_ok(t_z, 11'(MAP_Z));
          vx     <= t_x[32 +: XW];
          vy     <= t_y[32 +: YW];
          vz     <= t_z[32 +: ZW];
          state  <= amde_pkg::ST_IDX;
        end
        amde_pkg::ST_IDX: begin
          idx    <= AW'(vx) + SX * (AW'(vy) + AW'(MAP_Y) * AW'(vz));
          rd_cnt <= amde_pkg::TAP_C;
          state  <= in_map ? amde_pkg::ST_RD : amde_pkg::ST_FSAT;
        end
        amde_pkg::ST_RD: begin
          if (rd_cnt == amde_pkg::TAP_ZN) state <= amde_pkg::ST_DRN;
          else rd_cnt <= amde_pkg::tap_t'(rd_cnt + 3'd1);
        end
        amde_pkg::ST_DRN: state <= amde_pkg::ST_FMUL;
        amde_pkg::ST_FMUL: begin
          fp_x  <= 65'(m_x) * 65'(force_scale);
          fp_y  <= 65'(m_y) * 65'(force_scale);
          fp_z  <= 65'(m_z) * 65'(force_scale);
          fn_x  <= d_x[32];
          fn_y  <= d_y[32];
          fn_z  <= d_z[32];
          state <= amde_pkg::ST_FSAT;
        end
        amde_pkg::ST_FSAT: begin
          res_fx   <= in_map ? amde_pkg::sat_force(fn_x, fp_x) : 40'd0;
          res_fy   <= in_map ? amde_pkg::sat_force(fn_y, fp_y) : 40'd0;
          res_fz   <= in_map ? amde_pkg::sat_force(fn_z, fp_z) : 40'd0;
          res_last <= last_r;
          res_na   <= 1'b0;
          res_en   <= '0;
          if (last_r) begin
            // hand the molecule totals to the divider and clear them
            density_sum <= '0;
            atom_count  <= '0;
            div_den     <= cnt_new;
            div_neg     <= sum_new[55];
            div_q       <= sum_new[55] ? 56'(-sum_new) : 56'(sum_new);
            div_rem     <= '0;
            div_cnt     <= 6'(amde_pkg::DIV_STEPS - 1);
            if (cnt_new == 24'd0) begin
              res_na <= 1'b1;
              state  <= amde_pkg::ST_DONE;
            end else begin
              state  <= amde_pkg::ST_DIV;
            end
          end else begin
            density_sum <= sum_new;
            atom_count  <= cnt_new;
            state       <= amde_pkg::ST_DONE;
          end
        end
        amde_pkg::ST_DIV: begin
          div_rem <= div_bit ? 24'(div_sh - {1'b0, div_den}) : div_sh[23:0];
          div_q   <= {div_q[54:0], div_bit};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd0) state <= amde_pkg::ST_EMUL;
        end
        amde_pkg::ST_EMUL: begin
          e_prod <= 64'(mean_mag)
                    * 64'($unsigned(energy_gain[31] ? -energy_gain : energy_gain));
          e_neg  <= div_neg ^ energy_gain[31];
          state  <= amde_pkg::ST_EFIN;
        end
        amde_pkg::ST_EFIN: begin
          res_en <= e_sat;
          state  <= amde_pkg::ST_DONE;
        end
        amde_pkg::ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid    <= 1'b1;
            force_x      <= res_fx;
            force_y      <= res_fy;
            force_z      <= res_fz;
            atom_inside  <= in_map;
            energy       <= res_en;
            energy_valid <= res_last;
            no_atoms     <= res_na;
            state        <= amde_pkg::ST_IDLE;
          end
        end
        default: state <= amde_pkg::ST_IDLE;
      endcase
    end
  end

  // Checks
  a_atom_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && req_type == amde_pkg::REQ_ATOM) |=> state == amde_pkg::ST_MUL)
    else $error("atom accepted without starting the sequence");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    atom_count <= CNT_MAX)
    else $error("atom count above its cap");

  a_na_energy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_atoms) |-> energy_valid)
    else $error("empty flag without energy");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !wr_en)
    else $error("map write during stencil read");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == amde_pkg::ST_DIV && div_cnt != 6'd0) |=> state == amde_pkg::ST_DIV)
    else $error("division left early");

endmodule
